// ===== rtl/wsd_pkg.sv =====
// ============================================================================
// wsd_pkg
// Shared constants and types for the Welford sum-of-squared-deviations block.
// ============================================================================
package wsd_pkg;

  // Default widths of the sample and of the sample counter.
  localparam int unsigned SampleWidthDef = 32;
  localparam int unsigned CountWidthDef  = 32;

  // Fixed port widths of the stream fields.
  localparam int unsigned SampleFieldW = 32;
  localparam int unsigned SumW         = 63;

  // Bit positions of the input flags inside in_tuser.
  localparam int unsigned UserPresentBit = 0;
  localparam int unsigned UserStartBit   = 1;
  localparam int unsigned UserErrorBit   = 2;

  // Digit width of the iterative multiplier.
  localparam int unsigned MulDigitW = 16;

  // Handshake status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } wsd_unit_stat_t;

endpackage

// ===== rtl/wsd_div.sv =====
// ============================================================================
// wsd_div
// Restoring radix-2 divider: one quotient bit per cycle.
// ============================================================================
module wsd_div
  import wsd_pkg::*;
#(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output wsd_unit_stat_t stat
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [VW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [VW:0]     trial;
  logic [VW:0]     trial_sub;
  logic            ge;

  // One trial subtraction of the shifted remainder against the divisor.
  assign trial     = {rem_r, quo_r[DW-1]};
  assign ge        = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CntW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[VW-1:0] : trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/wsd_mul.sv =====
// ============================================================================
// wsd_mul
// Iterative unsigned multiplier: one 16-bit digit of b per cycle, shift-add.
// ============================================================================
module wsd_mul
  import wsd_pkg::*;
#(
  parameter int unsigned AW = 48,
  parameter int unsigned ND = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [AW-1:0]      b,
  output logic [AW+MulDigitW*ND-1:0] product,
  output wsd_unit_stat_t     stat
);

  localparam int unsigned BW   = MulDigitW * ND;
  localparam int unsigned PW   = AW + BW;
  localparam int unsigned PadW = PW - AW - MulDigitW;
  localparam int unsigned CntW = $clog2(ND + 1);

  logic [AW-1:0]           a_r;
  logic [BW-1:0]           b_r;
  logic [PW-1:0]           acc_r, acc_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [AW+MulDigitW-1:0] partial;
  logic [BW-1:0]           b_ext;

  // Multiplier operand widened to a whole number of digits.
  assign b_ext = BW'(b);

  // One digit product, added at the top of the shifting accumulator.
  assign partial = (AW + MulDigitW)'(a_r) * (AW + MulDigitW)'(b_r[MulDigitW-1:0]);

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      cnt_nxt  = CntW'(ND);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {{MulDigitW{1'b0}}, acc_r[PW-1:MulDigitW]} + {partial, {PadW{1'b0}}};
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operands and accumulator; the multiplier digits shift out from the bottom.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start) begin
      a_r <= a;
      b_r <= b_ext;
    end else if (busy_r) begin
      b_r <= {{MulDigitW{1'b0}}, b_r[BW-1:MulDigitW]};
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/welford_sum_sq_dev.sv =====
// ============================================================================
// welford_sum_sq_dev
// One-pass (Welford) accumulator of the sum of squared deviations from the
// running mean, built around a serial divider and a digit multiplier.
// ============================================================================
//
//  channel | ports                         | beat contents
//  --------+-------------------------------+---------------------------------
//  input   | in_tvalid / in_tready         | tdata: sample_value; tuser:
//          | in_tdata[31:0], in_tuser[2:0] | present, start_group, error
//  result  | out_tvalid / out_tready       | tdata: sum_sq_dev; tuser:
//          | out_tdata[63:0], out_tuser[0] | result_null
//
// A beat with a sample goes from acceptance through the states DELTA, DIV,
// MEAN, DEV, MUL and SUM to FIN; the serial divider computing delta / count
// takes the longest of these. A beat without a sample goes from IDLE to FIN.
// One beat is in work at a time; in_tready is high only when the sequencer
// is idle. A result waiting on out_tready does not block the next input
// beat, only the write of the following result. Synchronous active-low
// reset clears the count, the mean and the sum.
//
module welford_sum_sq_dev
  import wsd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned COUNT_WIDTH  = CountWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_value
  input  logic [2:0]  in_tuser,   // [0] sample_present, [1] start_group, [2] upstream_error
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [62:0] sum_sq_dev, [63] zero
  output logic [0:0]  out_tuser   // [0] result_null
);

  localparam int unsigned MW   = SAMPLE_WIDTH + 16;
  localparam int unsigned ND   = (MW + MulDigitW - 1) / MulDigitW;
  localparam int unsigned PW   = MW + MulDigitW * ND;
  localparam int unsigned PXW  = PW + 96;
  localparam int unsigned EXTW = SAMPLE_WIDTH + SampleFieldW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DELTA = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_MEAN  = 8'b0000_1000,
    S_DEV   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_base;
  logic [MW-1:0]          mean_r;
  logic [SumW-1:0]        sum_r;
  logic [MW-1:0]          xq_r;
  logic                   err_r;
  logic                   neg_r;
  logic [MW-1:0]          mag_r;
  logic                   out_valid_r;
  logic [SumW-1:0]        out_sum_r;
  logic                   out_null_r;

  logic                   in_acc;
  logic                   present, start_grp;
  logic [EXTW-1:0]        sample_ext;
  logic [MW:0]            diff;
  logic [MW:0]            diff_neg;
  logic [MW-1:0]          mag_nxt;
  logic [MW-1:0]          dev_nxt;
  logic [MW-1:0]          quo;
  logic [PW-1:0]          prod;
  logic [PXW-1:0]         prod_ext;
  logic                   prod_sat;
  logic [SumW-1:0]        inc;
  logic [SumW:0]          sum_add;
  logic                   out_free;
  logic                   is_null;
  wsd_unit_stat_t         div_stat, mul_stat;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign present   = in_tuser[UserPresentBit];
  assign start_grp = in_tuser[UserStartBit];
  assign out_free  = !out_valid_r || out_tready;

  // Low SAMPLE_WIDTH bits of the field, zero-extended and scaled to Q32.16.
  assign sample_ext = {{SAMPLE_WIDTH{1'b0}}, in_tdata};

  // Signed delta between sample and old mean, split into sign and magnitude.
  assign diff     = {xq_r[MW-1], xq_r} - {mean_r[MW-1], mean_r};
  assign diff_neg = -diff;
  assign mag_nxt  = diff[MW] ? diff_neg[MW-1:0] : diff[MW-1:0];

  // Deviation from the new mean; the mean never crosses the sample.
  assign dev_nxt = neg_r ? (mean_r - xq_r) : (xq_r - mean_r);

  // Product scaled from Q.32 to Q.0 with saturation of the increment.
  assign prod_ext = PXW'(prod);
  assign prod_sat = |prod_ext[PXW-1:95];
  assign inc      = prod_sat ? {SumW{1'b1}} : prod_ext[94:32];
  assign sum_add  = {1'b0, sum_r} + {1'b0, inc};

  // Count after a possible group start, before this sample is counted.
  assign count_base = start_grp ? '0 : count_r;
  assign is_null    = (count_r == '0) || err_r;

  wsd_div #(
    .DW (MW),
    .VW (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (st_r == S_DELTA),
    .dividend (mag_nxt),
    .divisor  (count_r),
    .quotient (quo),
    .stat     (div_stat)
  );

  wsd_mul #(
    .AW (MW),
    .ND (ND)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (st_r == S_DEV),
    .a       (mag_r),
    .b       (dev_nxt),
    .product (prod),
    .stat    (mul_stat)
  );

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt = present ? S_DELTA : S_FIN;
        end
      end
      S_DELTA: st_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done && !div_stat.busy) begin
          st_nxt = S_MEAN;
        end
      end
      S_MEAN: st_nxt = S_DEV;
      S_DEV:  st_nxt = S_MUL;
      S_MUL: begin
        if (mul_stat.done && !mul_stat.busy) begin
          st_nxt = S_SUM;
        end
      end
      S_SUM: st_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Group state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      mean_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_acc) begin
        if (present && (count_base != '1)) begin
          count_r <= count_base + COUNT_WIDTH'(1);
        end else begin
          count_r <= count_base;
        end
        if (start_grp) begin
          mean_r <= '0;
          sum_r  <= '0;
        end
      end
      if (st_r == S_MEAN) begin
        mean_r <= neg_r ? (mean_r - quo) : (mean_r + quo);
      end
      if (st_r == S_SUM) begin
        sum_r <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
      end
      if ((st_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xq_r  <= {sample_ext[SAMPLE_WIDTH-1:0], 16'h0000};
      err_r <= in_tuser[UserErrorBit];
    end
    if (st_r == S_DELTA) begin
      neg_r <= diff[MW];
      mag_r <= mag_nxt;
    end
    if ((st_r == S_FIN) && out_free) begin
      out_sum_r  <= is_null ? '0 : sum_r;
      out_null_r <= is_null;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_sum_r};
  assign out_tuser  = out_null_r;

endmodule
